@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the section time profiler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/stp_pkg.sv @@
// Types and constants of the section time profiler
`default_nettype none

package stp_pkg;

   // Event codes; codes five to seven are ignored
   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_MARK  = 3'd1,
      OP_END   = 3'd2,
      OP_QUERY = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BUSY     = 3'd1,
      ST_RANGE    = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_NORUNS   = 3'd4,
      ST_IDLE     = 3'd5
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_READ = 2'd1,
      S_EXEC = 2'd2,
      S_DIV  = 2'd3
   } fsm_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
      logic div_start;
      logic finish;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } dp_stat_type;

   localparam int DATA_W    = 32;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

endpackage

`default_nettype wire

@@ sv/stp_div.sv @@
// Iterative restoring divider, one quotient bit per cycle
`default_nettype none

module stp_div import stp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic                   done,
   output logic [DATA_W-1:0]      quotient
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic [DATA_W:0]      shifted;
   logic [DATA_W:0]      diff;

   // Shift in the next dividend bit and try the subtract
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (run_ff) begin
         if (diff[DATA_W]) begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand flops
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ sv/stp_ctrl.sv @@
// Controller state machine of the section time profiler
`default_nettype none

module stp_ctrl import stp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire dp_stat_type stat,
   output logic             busy,
   output dp_cmd_type       cmd
);

   fsm_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_READ;
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            state_in = stat.need_div ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         S_READ: ;
         S_EXEC: begin
            cmd.commit    = 1'b1;
            cmd.div_start = stat.need_div;
            cmd.finish    = !stat.need_div;
         end
         S_DIV: begin
            cmd.finish = stat.div_done;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/stp_dp.sv @@
// Datapath of the section time profiler: state, section memory, divider
`default_nettype none

module stp_dp import stp_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        cmd,
   output dp_stat_type            stat,
   input  wire logic [2:0]        req_opcode,
   input  wire logic [DATA_W-1:0] req_timestamp,
   input  wire logic [3:0]        req_query_index,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [DATA_W-1:0]      rsp_avg_time,
   output logic [DATA_W-1:0]      rsp_max_time,
   output logic [3:0]             rsp_section_count
);

   localparam int AW  = $clog2(MAX_SLOTS);
   localparam int NSW = $clog2(MAX_SLOTS + 1);
   localparam int CW  = NSW + 4;

   // Captured transaction
   op_type            op_ff;
   logic [DATA_W-1:0] ts_ff;
   logic [3:0]        qi_ff;

   // Profiler state
   logic [DATA_W-1:0]    last_ff, last_in;
   logic [NSW-1:0]       next_ff, next_in;
   logic                 active_ff, active_in;
   logic [DATA_W-1:0]    runs_ff, runs_in;
   logic [MAX_SLOTS-1:0] valid_ff, valid_in;

   // Section memory
   logic [DATA_W-1:0] tot_mem [MAX_SLOTS];
   logic [DATA_W-1:0] pk_mem  [MAX_SLOTS];
   logic [DATA_W-1:0] rd_tot_ff, rd_pk_ff;
   logic              rd_valid_ff;
   logic [DATA_W-1:0] cur_tot, cur_pk;
   logic              mem_we;

   // Response
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] rsp_avg_ff, rsp_max_ff;
   logic [3:0]        rsp_count_ff;

   logic [CW-1:0]     sec_wide, qi_wide, rec_wide, rec_next_wide;
   logic [AW-1:0]     sec_addr, rd_addr;
   logic [DATA_W-1:0] dur, new_tot, new_pk;
   status_type        close_st, query_st, ev_st;
   logic              div_done;
   logic [DATA_W-1:0] quotient;

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= op_type'(req_opcode);
         ts_ff <= req_timestamp;
         qi_ff <= req_query_index;
      end
   end

   // Address of the open section and of the queried section
   assign sec_wide = CW'(next_ff) - CW'(1);
   assign qi_wide  = CW'(qi_ff);
   assign rec_wide = (next_ff == '0) ? '0 : sec_wide;
   assign sec_addr = sec_wide[AW-1:0];
   assign rd_addr  = (op_ff == OP_QUERY) ? qi_wide[AW-1:0] : sec_addr;

   // Read the section memory; entries never written since clear read as zero
   always_ff @(posedge clock) begin
      rd_tot_ff   <= tot_mem[rd_addr];
      rd_pk_ff    <= pk_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      if (mem_we) begin
         tot_mem[sec_addr] <= new_tot;
         pk_mem[sec_addr]  <= new_pk;
      end
   end

   assign cur_tot = rd_valid_ff ? rd_tot_ff : '0;
   assign cur_pk  = rd_valid_ff ? rd_pk_ff : '0;

   // Duration of the closing section
   assign dur     = ts_ff - last_ff;
   assign new_tot = cur_tot + dur;
   assign new_pk  = (dur > cur_pk) ? dur : cur_pk;

   // Status of a mark or end
   always_comb begin
      if (!active_ff) begin
         close_st = ST_IDLE;
      end else if (next_ff == '0 || next_ff >= NSW'(MAX_SLOTS)) begin
         close_st = ST_OVERFLOW;
      end else begin
         close_st = ST_OK;
      end
   end

   // Status of a query
   always_comb begin
      if (active_ff) begin
         query_st = ST_BUSY;
      end else if (qi_wide >= rec_wide || qi_wide >= CW'(MAX_SLOTS)) begin
         query_st = ST_RANGE;
      end else if (runs_ff == '0) begin
         query_st = ST_NORUNS;
      end else begin
         query_st = ST_OK;
      end
   end

   always_comb begin
      case (op_ff)
         OP_MARK:  ev_st = close_st;
         OP_END:   ev_st = close_st;
         OP_QUERY: ev_st = query_st;
         default:  ev_st = ST_OK;
      endcase
   end

   // Next profiler state on commit
   always_comb begin
      last_in   = last_ff;
      next_in   = next_ff;
      active_in = active_ff;
      runs_in   = runs_ff;
      valid_in  = valid_ff;
      mem_we    = 1'b0;
      if (cmd.commit) begin
         case (op_ff)
            OP_START: begin
               last_in   = ts_ff;
               next_in   = NSW'(1);
               active_in = 1'b1;
            end
            OP_MARK, OP_END: begin
               if (close_st == ST_OK) begin
                  mem_we             = 1'b1;
                  valid_in[sec_addr] = 1'b1;
                  last_in            = ts_ff;
                  next_in            = next_ff + 1'b1;
                  if (op_ff == OP_END) begin
                     runs_in   = runs_ff + 1'b1;
                     active_in = 1'b0;
                  end
               end
            end
            OP_CLEAR: begin
               last_in   = '0;
               next_in   = '0;
               active_in = 1'b0;
               runs_in   = '0;
               valid_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         next_ff   <= '0;
         active_ff <= 1'b0;
         runs_ff   <= '0;
         valid_ff  <= '0;
      end else begin
         last_ff   <= last_in;
         next_ff   <= next_in;
         active_ff <= active_in;
         runs_ff   <= runs_in;
         valid_ff  <= valid_in;
      end
   end

   // Average: section total over completed runs
   stp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cur_tot),
      .divisor  (runs_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign stat.need_div = (op_ff == OP_QUERY) && (query_st == ST_OK);
   assign stat.div_done = div_done;

   // Sections recorded after the event
   assign rec_next_wide = (next_in == '0) ? '0 : (CW'(next_in) - CW'(1));

   // Present the result for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= ev_st;
         rsp_avg_ff    <= stat.need_div ? quotient : '0;
         rsp_max_ff    <= stat.need_div ? cur_pk : '0;
         rsp_count_ff  <= rec_next_wide[3:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_avg_time      = rsp_avg_ff;
   assign rsp_max_time      = rsp_max_ff;
   assign rsp_section_count = rsp_count_ff;

endmodule

`default_nettype wire

@@ sv/section_time_profiler_top.sv @@
// Section time profiler: start, busy, one strobe per event, no backpressure.
// Start, mark, end, clear and failed queries pass through the read and execute states;
// the result strobe is registered after execute, and the next event is accepted in that cycle.
// A successful query adds a pass of the bit-serial 32-bit divider before the strobe.
// Synchronous reset clears the profile, run count and all section statistics.
`default_nettype none
`include "assert_macros.svh"

module section_time_profiler_top import stp_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [2:0]        req_opcode,
   input  wire logic [DATA_W-1:0] req_timestamp,
   input  wire logic [3:0]        req_query_index,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [DATA_W-1:0]      rsp_avg_time,
   output logic [DATA_W-1:0]      rsp_max_time,
   output logic [3:0]             rsp_section_count
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequence each transaction
   stp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Hold state and statistics, compute results
   stp_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_timestamp     (req_timestamp),
      .req_query_index   (req_query_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_avg_time      (rsp_avg_time),
      .rsp_max_time      (rsp_max_time),
      .rsp_section_count (rsp_section_count)
   );

   // Checks on sequencing and result contents
   `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
   `ASSERT_SAME(a_rsp_idle, rsp_valid, !busy, "result strobe while a transaction is in flight")
   `ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe held for more than one cycle")
   `ASSERT_SAME(a_rsp_zero, rsp_valid && (rsp_status != ST_OK),
                (rsp_avg_time == '0) && (rsp_max_time == '0),
                "failed event returned nonzero statistics")

endmodule

`default_nettype wire
